// ===== rtl/core/nearest_neighbor_classifier_macros.svh =====
// Assertion macros shared by the nearest-neighbor classifier RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef NEAREST_NEIGHBOR_CLASSIFIER_MACROS_SVH
`define NEAREST_NEIGHBOR_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NNC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nnc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NNC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nnc assertion failed");

`endif

// ===== rtl/core/nnc_pkg.sv =====
// Shared types and constants of the nearest-neighbor classifier.
// No dependencies; every other file of the block but nnc_ram and the macro header imports it.
`default_nettype none

package nnc_pkg;

  localparam int unsigned MAX_VECTORS  = 1024;
  localparam int unsigned MAX_LENGTH   = 64;
  localparam int unsigned ELEMENT_BITS = 16;

  localparam int unsigned VIDX_W  = 10;
  localparam int unsigned EIDX_W  = 6;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned DIST_W  = 38;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned ABS_W   = ELEMENT_BITS;
  localparam int unsigned TERM_W  = 2 * ELEMENT_BITS;
  localparam int unsigned TADDR_W = VIDX_W + EIDX_W;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(MAX_LENGTH);

  typedef enum logic {
    FUNC_TRAIN = 1'b0,
    FUNC_QUERY = 1'b1
  } nnc_func_e;

  typedef enum logic {
    METRIC_L2 = 1'b0,
    METRIC_L1 = 1'b1
  } nnc_metric_e;

  typedef enum logic [1:0] {
    REG_VECTOR_LENGTH = 2'd0,
    REG_TRAIN_COUNT   = 2'd1,
    REG_METRIC        = 2'd2,
    REG_UNUSED        = 2'd3
  } nnc_reg_e;

  typedef struct packed {
    logic                           func;
    logic [VIDX_W-1:0]              vector_index;
    logic [EIDX_W-1:0]              element_index;
    logic signed [ELEMENT_BITS-1:0] value;
    logic [LABEL_W-1:0]             label;
  } nnc_in_t;

  typedef struct packed {
    logic               found;
    logic [LABEL_W-1:0] class_label;
    logic [VIDX_W-1:0]  match_index;
    logic [DIST_W-1:0]  best_distance;
  } nnc_out_t;

  // Effective configuration, already clamped to the supported ranges.
  typedef struct packed {
    logic [EIDX_W-1:0] len_m1;
    logic [CNT_W-1:0]  count;
    nnc_metric_e       metric;
  } nnc_cfg_t;

  // One decoded command, passed from the front end to the back end.
  typedef struct packed {
    nnc_func_e                func;
    logic [VIDX_W-1:0]        vector_index;
    logic [EIDX_W-1:0]        element_index;
    logic [ELEMENT_BITS-1:0]  value;
    logic [LABEL_W-1:0]       label;
    logic                     complete;
  } nnc_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/nearest_neighbor_classifier.sv =====
// Top level of the nearest-neighbor classifier: APB register file, front end,
// command queue and back end. Depends on nnc_pkg, nnc_front, nnc_fifo, nnc_back.
//
// The block is a one-nearest-neighbor classifier over signed 16-bit vectors.
// A training transaction (func 0) writes one element of stored vector
// vector_index together with that vector's class label and gives no
// result. A query transaction (func 1) writes one element of the query
// buffer; the element at position vector_length-1 completes the query and
// starts a search over stored vectors 0 to train_count-1, using the squared
// Euclidean (metric 0) or Manhattan (metric 1) distance, summed exactly in
// 38 bits. One result transaction follows each completing query: the label,
// index and distance of the first strictly nearest vector, or found = 0
// with all other fields zero when train_count is 0. A completing query
// occupies the back end through the search, the pipeline drain and the
// label lookup: the search reads one element pair per cycle from the
// training memory's single read port. A four-entry command queue sits
// between the front end and the back end, so input transactions keep being
// accepted while a search runs or a result waits to be taken, until the
// queue is full. vector_length 0 acts as 1 and values above 64 act as 64;
// train_count above 1024 acts as 1024. Registers sit at byte addresses 0
// (vector_length), 4 (train_count) and 8 (metric) and should be written only
// while the block is idle. Stores are not cleared at reset: a search must
// only touch entries that were written.
`default_nettype none

module nearest_neighbor_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  nnc_pkg::nnc_in_t              in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output nnc_pkg::nnc_out_t             out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nnc_pkg::PADDR_W-1:0]   paddr,
  input  logic [nnc_pkg::PDATA_W-1:0]   pwdata,
  output logic [nnc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import nnc_pkg::*;

  logic [LEN_W-1:0] vector_length_q;
  logic [CNT_W-1:0] train_count_q;
  logic             metric_q;
  nnc_reg_e         reg_sel;
  logic             reg_write;

  nnc_cfg_t cfg;
  logic     q_full, q_push, q_valid, q_pop;
  nnc_cmd_t q_push_cmd, q_pop_cmd;

  // Register access: the index is the word address.
  assign reg_sel   = nnc_reg_e'(paddr[3:2]);
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_length_q <= LENGTH_RESET;
      train_count_q   <= '0;
      metric_q        <= 1'b0;
    end else if (reg_write) begin
      case (reg_sel)
        REG_VECTOR_LENGTH: vector_length_q <= pwdata[LEN_W-1:0];
        REG_TRAIN_COUNT:   train_count_q   <= pwdata[CNT_W-1:0];
        REG_METRIC:        metric_q        <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VECTOR_LENGTH: prdata = PDATA_W'(vector_length_q);
      REG_TRAIN_COUNT:   prdata = PDATA_W'(train_count_q);
      REG_METRIC:        prdata = PDATA_W'(metric_q);
      default:           prdata = '0;
    endcase
  end

  // Clamp the registers to the ranges the datapath supports.
  always_comb begin
    if (vector_length_q == '0) begin
      cfg.len_m1 = '0;
    end else if (vector_length_q > LEN_W'(MAX_LENGTH)) begin
      cfg.len_m1 = EIDX_W'(MAX_LENGTH - 1);
    end else begin
      cfg.len_m1 = EIDX_W'(vector_length_q - 1'b1);
    end
    if (train_count_q > CNT_W'(MAX_VECTORS)) begin
      cfg.count = CNT_W'(MAX_VECTORS);
    end else begin
      cfg.count = train_count_q;
    end
    cfg.metric = metric_q ? METRIC_L1 : METRIC_L2;
  end

  nnc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  nnc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_pop_cmd)
  );

  nnc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_pop_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/nnc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`default_nettype none

module nnc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/nnc_front.sv =====
// Front end of the classifier: accepts input transactions and decodes them.
// Depends on nnc_pkg.
`default_nettype none

module nnc_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nnc_pkg::nnc_in_t  in_i,
  input  nnc_pkg::nnc_cfg_t cfg_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output nnc_pkg::nnc_cmd_t q_cmd_o
);
  import nnc_pkg::*;

  logic is_query;

  // Every index the port can carry lies inside the stores, so nothing is dropped.
  assign is_query   = (in_i.func == FUNC_QUERY);
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o               = '0;
    q_cmd_o.func          = is_query ? FUNC_QUERY : FUNC_TRAIN;
    q_cmd_o.vector_index  = in_i.vector_index;
    q_cmd_o.element_index = in_i.element_index;
    q_cmd_o.value         = in_i.value;
    q_cmd_o.label         = in_i.label;
    // A query element at the last position in use starts a search.
    q_cmd_o.complete      = is_query && (in_i.element_index == cfg_i.len_m1);
  end

endmodule

`default_nettype wire

// ===== rtl/core/nnc_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on nnc_pkg.
`default_nettype none

module nnc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nnc_pkg::nnc_cmd_t push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output nnc_pkg::nnc_cmd_t pop_cmd_o
);
  import nnc_pkg::*;

  nnc_cmd_t              slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nnc_back.sv =====
// Back end of the classifier: owns the stores, runs the distance search and
// holds the result register. Depends on nnc_pkg, nnc_ram and the macro header.
`default_nettype none

`include "nearest_neighbor_classifier_macros.svh"

module nnc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nnc_pkg::nnc_cfg_t cfg_i,
  input  logic              cmd_valid_i,
  input  nnc_pkg::nnc_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nnc_pkg::nnc_out_t out_o
);
  import nnc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_LABEL
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [VIDX_W-1:0] idx;
  } tag_t;

  state_e            state_q;
  logic [VIDX_W-1:0] t_q;
  logic [EIDX_W-1:0] e_q;
  logic [VIDX_W-1:0] cnt_m1;
  logic              issue, issue_last;

  tag_t              p1_q, p2_q, p3_q, p4_q;
  logic [ABS_W-1:0]  absd_q;
  logic [TERM_W-1:0] term_q;
  logic [DIST_W-1:0] acc_q, acc_d;
  logic [DIST_W-1:0] sum_q;
  logic              have_q;
  logic [DIST_W-1:0] best_q;
  logic [VIDX_W-1:0] best_idx_q;

  logic                    out_valid_q;
  nnc_out_t                out_q;

  logic                    we_train, we_query;
  logic [ELEMENT_BITS-1:0] train_rdata, query_rdata;
  logic [LABEL_W-1:0]      label_rdata;
  logic signed [ELEMENT_BITS:0] diff;
  logic [ELEMENT_BITS:0]   neg_diff;
  logic [ABS_W-1:0]        absd;
  logic                    pipe_busy;

  // A completing query needs a free result register; training writes do not.
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i && (!cmd_i.complete || !out_valid_q);
  assign we_train  = cmd_pop_o && (cmd_i.func == FUNC_TRAIN);
  assign we_query  = cmd_pop_o && (cmd_i.func == FUNC_QUERY);

  assign cnt_m1     = VIDX_W'(cfg_i.count - 1'b1);
  assign issue      = (state_q == ST_SEARCH);
  assign issue_last = (e_q == cfg_i.len_m1);
  assign pipe_busy  = p1_q.valid || p2_q.valid || p3_q.valid || p4_q.valid;

  nnc_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_VECTORS * MAX_LENGTH)) u_train_ram (
    .clk_i   (clk_i),
    .we_i    (we_train),
    .waddr_i ({cmd_i.vector_index, cmd_i.element_index}),
    .wdata_i (cmd_i.value),
    .raddr_i ({t_q, e_q}),
    .rdata_o (train_rdata)
  );

  nnc_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VECTORS)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (we_train),
    .waddr_i (cmd_i.vector_index),
    .wdata_i (cmd_i.label),
    .raddr_i (best_idx_q),
    .rdata_o (label_rdata)
  );

  nnc_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_LENGTH)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (we_query),
    .waddr_i (cmd_i.element_index),
    .wdata_i (cmd_i.value),
    .raddr_i (e_q),
    .rdata_o (query_rdata)
  );

  // Element difference, sign-extended by one bit so it cannot wrap.
  always_comb begin
    diff     = $signed({query_rdata[ELEMENT_BITS-1], query_rdata}) -
               $signed({train_rdata[ELEMENT_BITS-1], train_rdata});
    neg_diff = (ELEMENT_BITS+1)'(-diff);
    absd     = diff[ELEMENT_BITS] ? neg_diff[ABS_W-1:0] : diff[ABS_W-1:0];
    acc_d    = (p3_q.first ? '0 : acc_q) + DIST_W'(term_q);
  end

  // Distance pipeline: read, absolute difference, term, accumulate, compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q   <= '0;
      p2_q   <= '0;
      p3_q   <= '0;
      p4_q   <= '0;
      have_q <= 1'b0;
    end else begin
      p1_q.valid <= issue;
      p1_q.first <= (e_q == '0);
      p1_q.last  <= issue_last;
      p1_q.idx   <= t_q;
      p2_q       <= p1_q;
      p3_q       <= p2_q;
      p4_q.valid <= p3_q.valid && p3_q.last;
      p4_q.first <= p3_q.first;
      p4_q.last  <= p3_q.last;
      p4_q.idx   <= p3_q.idx;
      if (cmd_pop_o && cmd_i.complete) begin
        have_q <= 1'b0;
      end else if (p4_q.valid) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    absd_q     <= absd;
    term_q     <= (cfg_i.metric == METRIC_L1) ? TERM_W'(absd_q) : absd_q * absd_q;
    if (p3_q.valid) begin
      acc_q <= acc_d;
    end
    if (p3_q.valid && p3_q.last) begin
      sum_q <= acc_d;
    end
    // Strict compare keeps the lowest index among equal distances.
    if (p4_q.valid && (!have_q || (sum_q < best_q))) begin
      best_q     <= sum_q;
      best_idx_q <= p4_q.idx;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t_q         <= '0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && cmd_i.complete) begin
            if (cfg_i.count == '0) begin
              out_valid_q <= 1'b1;
              out_q       <= '0;
            end else begin
              t_q     <= '0;
              e_q     <= '0;
              state_q <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (issue_last) begin
            e_q <= '0;
            if (t_q == cnt_m1) begin
              state_q <= ST_DRAIN;
            end else begin
              t_q <= t_q + 1'b1;
            end
          end else begin
            e_q <= e_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state_q <= ST_LABEL;
          end
        end
        ST_LABEL: begin
          out_valid_q         <= 1'b1;
          out_q.found         <= 1'b1;
          out_q.class_label   <= label_rdata;
          out_q.match_index   <= best_idx_q;
          out_q.best_distance <= best_q;
          state_q             <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `NNC_ASSERT_IMP(a_search_in_range, state_q == ST_SEARCH, (e_q <= cfg_i.len_m1) && (t_q <= cnt_m1))
  `NNC_ASSERT_NXT(a_compare_sets_best, p4_q.valid, have_q)
  `NNC_ASSERT_IMP(a_result_slot_free, state_q == ST_LABEL, !out_valid_q && have_q)
  `NNC_ASSERT_IMP(a_empty_is_zero, out_valid_q && !out_q.found, out_q == '0)

endmodule

`default_nettype wire

// ===== tb/nnc_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the nearest-neighbor classifier testbench: a predictor that keeps its
// own copy of the stored vectors, labels, query buffer and registers. Depends on nnc_pkg.
package nnc_scoreboard_pkg;
  import nnc_pkg::*;

  class nnc_scoreboard;
    logic signed [ELEMENT_BITS-1:0] stored_elems [MAX_VECTORS*MAX_LENGTH];
    logic [LABEL_W-1:0]             stored_labels [MAX_VECTORS];
    logic signed [ELEMENT_BITS-1:0] query_elems [MAX_LENGTH];
    logic [LEN_W-1:0]               length_reg;
    logic [CNT_W-1:0]               count_reg;
    nnc_metric_e                    metric_reg;
    nnc_out_t                       awaited_results [$];
    int unsigned                    errors;

    function new();
      length_reg = LENGTH_RESET;
      count_reg  = '0;
      metric_reg = METRIC_L2;
      errors     = 0;
    endfunction

    function void set_register(nnc_reg_e idx, logic [PDATA_W-1:0] data);
      case (idx)
        REG_VECTOR_LENGTH: length_reg = data[LEN_W-1:0];
        REG_TRAIN_COUNT:   count_reg = data[CNT_W-1:0];
        REG_METRIC:        metric_reg = nnc_metric_e'(data[0]);
        default: ;
      endcase
    endfunction

    // A length of zero behaves as one; anything past the buffer size is clamped.
    function int unsigned active_length();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_LENGTH) return MAX_LENGTH;
      return length_reg;
    endfunction

    function int unsigned active_count();
      return (count_reg > MAX_VECTORS) ? MAX_VECTORS : count_reg;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function longint unsigned distance_to(int unsigned row, int unsigned len);
      longint unsigned sum;
      longint unsigned gap;
      int              diff;
      int unsigned     pos;
      sum = 0;
      for (pos = 0; pos < len; pos++) begin
        diff = int'(query_elems[pos]) - int'(stored_elems[row * MAX_LENGTH + pos]);
        gap = (diff < 0) ? -diff : diff;
        sum += (metric_reg == METRIC_L1) ? gap : gap * gap;
      end
      return sum;
    endfunction

    // Called for every accepted input transaction, in acceptance order.
    function void note_input(nnc_in_t item);
      int unsigned     len;
      int unsigned     cnt;
      int unsigned     row;
      longint unsigned row_distance;
      longint unsigned best_dist;
      nnc_out_t        result;
      if (item.func == FUNC_TRAIN) begin
        stored_elems[item.vector_index * MAX_LENGTH + item.element_index] = item.value;
        stored_labels[item.vector_index] = item.label;
        return;
      end
      query_elems[item.element_index] = item.value;
      len = active_length();
      if (item.element_index != len - 1) return;
      cnt = active_count();
      result = '0;
      best_dist = 0;
      // Strict less-than keeps the lowest index among equal distances.
      for (row = 0; row < cnt; row++) begin
        row_distance = distance_to(row, len);
        if (row == 0 || row_distance < best_dist) begin
          best_dist = row_distance;
          result.found = 1'b1;
          result.class_label = stored_labels[row];
          result.match_index = row[VIDX_W-1:0];
          result.best_distance = best_dist[DIST_W-1:0];
        end
      end
      awaited_results.push_back(result);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(nnc_out_t got);
      nnc_out_t want;
      if (awaited_results.size() == 0) begin
        $display({"%0t: unexpected result: expected none, actual found %0d label %0d",
                  " index %0d distance %0d"},
                 $time, got.found, got.class_label, got.match_index, got.best_distance);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("class_label", want.class_label, got.class_label);
      compare_field("match_index", want.match_index, got.match_index);
      compare_field("best_distance", want.best_distance, got.best_distance);
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level testbench of the nearest-neighbor classifier: clock, reset, drivers, monitors
// and stimulus. Depends on nnc_pkg, nnc_scoreboard_pkg and the nearest_neighbor_classifier RTL.
module tb_top;
  import nnc_pkg::*;
  import nnc_scoreboard_pkg::*;

  // The longest search the stimulus ever asks for is 192 element pairs; a run in which
  // nothing moves for far longer than that is hung.
  localparam int unsigned QUIET_LIMIT  = 20000;
  // Enough for a full command queue of transactions that give no result, plus the pipeline.
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned CALM_AFTER   = 250;

  localparam logic [ELEMENT_BITS-1:0] MOST_NEGATIVE = 16'h8000;
  localparam logic [ELEMENT_BITS-1:0] MOST_POSITIVE = 16'h7fff;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  nnc_in_t            in_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  nnc_out_t           out_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  nnc_scoreboard sb;

  // Bookkeeping for the stimulus: which stored elements and which query positions have
  // been written since reset. A search may only ever touch written entries.
  logic [MAX_LENGTH-1:0] trained [MAX_VECTORS];
  logic [MAX_LENGTH-1:0] queried;
  int unsigned           eff_len;
  int unsigned           eff_cnt;
  int unsigned           items_sent;
  bit                    gaps_on;
  bit                    stalls_on = 1'b0;
  int unsigned           stall_left = 0;

  nearest_neighbor_classifier dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_i,
    .out_valid_o,
    .out_ready_i,
    .out_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Result side: while stalls are enabled, ready drops at random and stall_left keeps it low for the rest of the burst.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Both monitors sample the values from just before the edge, so the order in which
  // processes run within the time step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_o);
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Presents one input transaction and returns at the edge that accepts it. Valid is left
  // high so that a following transaction keeps it high without a glitch; anything that
  // is not another transaction lowers it first.
  task automatic send_item(nnc_in_t item);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic train_elem(int unsigned row, int unsigned pos, logic [ELEMENT_BITS-1:0] val,
                            logic [LABEL_W-1:0] lab);
    nnc_in_t item;
    item.func = FUNC_TRAIN;
    item.vector_index = VIDX_W'(row);
    item.element_index = EIDX_W'(pos);
    item.value = val;
    item.label = lab;
    send_item(item);
    trained[row][pos] = 1'b1;
  endtask

  // The vector index and label of a query are don't-cares, so they carry random bits.
  task automatic query_elem(int unsigned pos, logic [ELEMENT_BITS-1:0] val);
    nnc_in_t item;
    item.func = FUNC_QUERY;
    item.vector_index = VIDX_W'($urandom);
    item.element_index = EIDX_W'(pos);
    item.value = val;
    item.label = LABEL_W'($urandom);
    send_item(item);
    queried[pos] = 1'b1;
  endtask

  // Element values lean toward the extremes and toward small numbers, which makes equal
  // distances, and therefore ties, common.
  function automatic logic [ELEMENT_BITS-1:0] any_value();
    case ($urandom_range(0, 7))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2, 3:    return ELEMENT_BITS'($urandom_range(0, 6) - 3);
      default: return ELEMENT_BITS'($urandom);
    endcase
  endfunction

  // Waits until every expected result has been taken, then lets the command queue and
  // the pipeline run empty of transactions that give no result.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One APB write. The caller releases the bus after the last of a series, so that a
  // back-to-back write keeps psel high instead of toggling it within one time step.
  task automatic write_reg(nnc_reg_e idx, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  task automatic configure(int unsigned len_raw, int unsigned cnt_raw, nnc_metric_e met);
    settle();
    write_reg(REG_VECTOR_LENGTH, len_raw);
    write_reg(REG_TRAIN_COUNT, cnt_raw);
    write_reg(REG_METRIC, met);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    eff_len = sb.active_length();
    eff_cnt = sb.active_count();
  endtask

  // Writes every element that the next search will read and that was never written.
  task automatic fill_set();
    int unsigned row;
    int unsigned pos;
    for (row = 0; row < eff_cnt; row++) begin
      for (pos = 0; pos < eff_len; pos++) begin
        if (!trained[row][pos]) train_elem(row, pos, any_value(), LABEL_W'($urandom));
      end
    end
  endtask

  // A well-formed query: the leading elements in a rotated order (rewriting some that
  // already hold data), sprinkled with training overwrites and elements past the length,
  // and finally the element that completes the query.
  task automatic run_query();
    int unsigned rot;
    int unsigned k;
    int unsigned pos;
    rot = $urandom_range(0, MAX_LENGTH - 1);
    for (k = 0; k + 1 < eff_len; k++) begin
      pos = (k + rot) % (eff_len - 1);
      if (!queried[pos] || $urandom_range(0, 2) != 0) query_elem(pos, any_value());
      case ($urandom_range(0, 9))
        0: train_elem($urandom_range(0, MAX_VECTORS - 1), $urandom_range(0, MAX_LENGTH - 1),
                      any_value(), LABEL_W'($urandom));
        1: if (eff_len < MAX_LENGTH) query_elem($urandom_range(eff_len, MAX_LENGTH - 1), any_value());
        default: ;
      endcase
    end
    query_elem(eff_len - 1, any_value());
  endtask

  initial begin : stimulus
    int unsigned len_raw;
    int unsigned cnt_raw;
    int unsigned random_start;
    int unsigned pos;
    int unsigned r;
    bit          long_rows;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    queried = '0;
    foreach (trained[v]) trained[v] = '0;
    items_sent = 0;
    gaps_on = 1'b1;
    sb = new();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    stalls_on <= 1'b1;

    // Empty set: a completing query with no stored vectors reports not-found. The second
    // element lies past the length and is only stored.
    configure(1, 0, METRIC_L2);
    query_elem(0, MOST_NEGATIVE);
    query_elem(MAX_LENGTH - 1, MOST_POSITIVE);

    // Three short vectors at the extremes, the last two equal so that they tie and the
    // lower index has to win. Then an exact hit on vector 0 under the Manhattan metric.
    configure(4, 3, METRIC_L2);
    for (pos = 0; pos < 4; pos++) train_elem(0, pos, MOST_NEGATIVE, 8'hff);
    for (pos = 0; pos < 4; pos++) train_elem(1, pos, MOST_POSITIVE, 8'h00);
    for (pos = 0; pos < 4; pos++) train_elem(2, pos, MOST_POSITIVE, 8'h5a);
    for (pos = 0; pos < 4; pos++) query_elem(pos, '0);
    configure(4, 3, METRIC_L1);
    for (pos = 0; pos < 4; pos++) query_elem(pos, MOST_NEGATIVE);

    // Largest distance: the longest vectors with every element difference at its maximum,
    // a length register above the buffer size, then the same under the Manhattan metric.
    configure(127, 1, METRIC_L2);
    for (pos = 0; pos < MAX_LENGTH; pos++) train_elem(0, pos, MOST_NEGATIVE, 8'h3c);
    for (pos = 0; pos < MAX_LENGTH; pos++) query_elem(pos, MOST_POSITIVE);
    configure(127, 1, METRIC_L1);
    query_elem(MAX_LENGTH - 1, MOST_POSITIVE);

    // Random phases. Each picks a setting, writes whatever the search will need, then runs
    // a few queries. Long vectors go with few stored vectors, and larger counts only with
    // length one. Near the end idling stops.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (items_sent - random_start >= CALM_AFTER) begin
        gaps_on = 1'b0;
        stalls_on <= 1'b0;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
        stalls_on <= ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 19);
      long_rows = (r >= 1 && r <= 4);
      if (r == 0) len_raw = 0;
      else if (r == 1) len_raw = $urandom_range(MAX_LENGTH, 127);
      else if (long_rows) len_raw = $urandom_range(9, 24);
      else len_raw = $urandom_range(1, 8);
      if (long_rows) cnt_raw = $urandom_range(0, 3);
      else if (len_raw <= 1 && $urandom_range(0, 2) == 0) cnt_raw = $urandom_range(0, 40);
      else cnt_raw = $urandom_range(0, 10);
      configure(len_raw, cnt_raw, nnc_metric_e'($urandom_range(0, 1)));
      fill_set();
      repeat (long_rows ? 1 : $urandom_range(1, 4)) run_query();
    end

    gaps_on = 1'b0;
    stalls_on <= 1'b0;
    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/nnc_pkg.sv
rtl/core/nnc_ram.sv
rtl/core/nnc_front.sv
rtl/core/nnc_fifo.sv
rtl/core/nnc_back.sv
rtl/core/nearest_neighbor_classifier.sv
tb/nnc_scoreboard_pkg.sv
tb/tb_top.sv
